### rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared constants for the momentum cartesian to spherical converter:
// field widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int MCS_COMP_WIDTH      = 24;
    localparam int MCS_ANGLE_FRAC_BITS = 16;
    localparam int MCS_CORDIC_STAGES   = 20;

    localparam int MCS_PT_W     = 24;
    localparam int MCS_PHI_W    = 19;
    localparam int MCS_THETA_W  = 18;
    localparam int MCS_OUT_W    = MCS_PT_W + MCS_PHI_W + MCS_THETA_W;
    localparam int MCS_OUT_DATA_W = ((MCS_OUT_W + 7) / 8) * 8;
    localparam int MCS_OUT_USER_W = 2;

    localparam int MCS_ANGLE_W  = 36;
    localparam int MCS_CORDIC_W = 64;
    localparam int MCS_SCALE_BITS = 60;
    localparam int MCS_ANGLE_UNIT_BITS = 30;

    localparam logic signed [63:0] MCS_PI_INT     = 64'sd3373259426;
    localparam logic signed [63:0] MCS_TWO_PI_INT = 64'sd6746518852;
    localparam logic signed [63:0] MCS_PT_MAX     = 64'sd11863283;

    localparam logic [31:0] MCS_ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

endpackage

### rtl/mcs_cordic.sv
// ----------------------------------------------------------------------------
// mcs_cordic
// Pipelined vectoring CORDIC: angle of (x, y) in units of 2^-30 rad, with
// half-plane folding for negative x. One vector per cycle while en is high.
// ----------------------------------------------------------------------------
module mcs_cordic
    import mcs_pkg::*;
#(
    parameter int COMP_WIDTH    = MCS_COMP_WIDTH,
    parameter int CORDIC_STAGES = MCS_CORDIC_STAGES
)
(
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [COMP_WIDTH+1:0]     x_in,
    input  logic signed [COMP_WIDTH+1:0]     y_in,
    output logic signed [MCS_ANGLE_W-1:0]    angle
);

    localparam int IW    = COMP_WIDTH + 2;
    localparam int DW    = MCS_CORDIC_W;
    localparam int AW    = MCS_ANGLE_W;
    localparam int GUARD = MCS_SCALE_BITS - COMP_WIDTH;
    localparam logic signed [AW-1:0] PI_A = AW'(MCS_PI_INT);

    logic signed [IW-1:0] xf;
    logic signed [IW-1:0] yf;
    logic                 neg;

    logic signed [DW-1:0] x_reg    [CORDIC_STAGES+1];
    logic signed [DW-1:0] y_reg    [CORDIC_STAGES+1];
    logic signed [AW-1:0] z_reg    [CORDIC_STAGES+1];
    logic signed [AW-1:0] base_reg [CORDIC_STAGES+1];
    logic                 zero_reg [CORDIC_STAGES+1];
    logic signed [AW-1:0] angle_reg;

    always_comb
    begin
        neg = x_in[IW-1];
        xf  = neg ? -x_in : x_in;
        yf  = neg ? -y_in : y_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= DW'(xf) <<< GUARD;
            y_reg[0]    <= DW'(yf) <<< GUARD;
            z_reg[0]    <= '0;
            base_reg[0] <= neg ? PI_A : '0;
            zero_reg[0] <= (yf == '0);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [AW-1:0] at;
        logic signed [DW-1:0] x_next;
        logic signed [DW-1:0] y_next;
        logic signed [AW-1:0] z_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            at = AW'(MCS_ATAN_TAB[i]);
            if (!y_reg[i][DW-1])
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + at;
            end
            else
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                base_reg[i+1] <= base_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[CORDIC_STAGES] ? base_reg[CORDIC_STAGES]
                       : base_reg[CORDIC_STAGES] + z_reg[CORDIC_STAGES];
        end
    end

    assign angle = angle_reg;

endmodule

### rtl/momentum_cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// momentum_cartesian_to_spherical
// Converts a momentum vector (px, py, pz) to pt, phi and theta, or passes
// pre-converted values through clamped to the output ranges.
//
//   channel | dir | fields
//   s_*     | in  | tdata: comp_x, comp_y, comp_z ; tuser: cartesian
//   m_*     | out | tdata: pt_out, phi_out, theta_out ; tuser: phi_ok, theta_ok
//
// One transaction per cycle unless stalled. Data passes the squaring registers,
// the one-bit-per-stage square root, the CORDIC pipeline and the output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module momentum_cartesian_to_spherical
    import mcs_pkg::*;
#(
    parameter int COMP_WIDTH      = MCS_COMP_WIDTH,
    parameter int ANGLE_FRAC_BITS = MCS_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = MCS_CORDIC_STAGES
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // comp_x, comp_y, comp_z, zero padding
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]       s_tdata,
    // cartesian
    input  logic                                    s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // pt_out, phi_out, theta_out, zero padding
    output logic [MCS_OUT_DATA_W-1:0]               m_tdata,
    // phi_ok, theta_ok
    output logic [MCS_OUT_USER_W-1:0]               m_tuser
);

    localparam int W   = COMP_WIDTH;
    localparam int NW  = 2 * W;
    localparam int RW  = W + 2;
    localparam int PW  = W + 1;
    localparam int CL  = CORDIC_STAGES + 2;
    localparam int NV  = 4 + W + CL;
    localparam int AW  = MCS_ANGLE_W;
    localparam int SH  = MCS_ANGLE_UNIT_BITS - ANGLE_FRAC_BITS;

    localparam logic signed [AW-1:0] PI_A     = AW'(MCS_PI_INT);
    localparam logic signed [AW-1:0] TWO_PI_A = AW'(MCS_TWO_PI_INT);
    localparam logic [AW-1:0] HALF_A      = AW'(1) << (SH - 1);
    localparam logic [AW-1:0] PHI_MAX_A   = AW'(MCS_TWO_PI_INT >>> SH);
    localparam logic [AW-1:0] THETA_MAX_A = AW'(MCS_PI_INT >>> SH);
    localparam logic signed [63:0] PHI_MAX_L   = MCS_TWO_PI_INT >>> SH;
    localparam logic signed [63:0] THETA_MAX_L = MCS_PI_INT >>> SH;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic                cart;
        logic                pok;
        logic                tok;
    } item_t;

    logic              en;
    logic [NV-1:0]     vld_reg;
    logic              m_tvalid_reg;

    item_t             in_item;
    item_t             in_reg;
    item_t             s1_item_reg;
    logic [NW-1:0]     sqx_reg;
    logic [NW-1:0]     sqy_reg;
    item_t             s2_item_reg;
    logic [NW-1:0]     n_reg;

    item_t             sq_item_reg [W];
    logic [RW-1:0]     sq_rem_reg  [W];
    logic [W-1:0]      sq_root_reg [W];
    logic [NW-1:0]     sq_n_reg    [W];

    item_t             rnd_item_reg;
    logic [PW-1:0]     rnd_pt_reg;

    item_t             cd_item_reg [CL];
    logic [PW-1:0]     cd_pt_reg   [CL];

    logic signed [AW-1:0] phi_ang;
    logic signed [AW-1:0] theta_ang;

    logic signed [AW-1:0] phi_a;
    logic signed [AW-1:0] theta_a;
    logic [AW-1:0]        phi_r;
    logic [AW-1:0]        theta_r;
    logic signed [63:0]   xe;
    logic signed [63:0]   ye;
    logic signed [63:0]   ze;
    item_t                it_end;
    logic [PW-1:0]        pt_end;

    logic [MCS_PT_W-1:0]    pt_next;
    logic [MCS_PHI_W-1:0]   phi_next;
    logic [MCS_THETA_W-1:0] theta_next;

    logic [MCS_PT_W-1:0]    pt_reg;
    logic [MCS_PHI_W-1:0]   phi_reg;
    logic [MCS_THETA_W-1:0] theta_reg;
    logic                   pok_reg;
    logic                   tok_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        in_item.x    = s_tdata[W-1:0];
        in_item.y    = s_tdata[2*W-1:W];
        in_item.z    = s_tdata[3*W-1:2*W];
        in_item.cart = s_tuser;
        in_item.pok  = (in_item.x != '0) || (in_item.y != '0);
        in_item.tok  = in_item.pok || (in_item.z != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[NV-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[NV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg      <= in_item;
            s1_item_reg <= in_reg;
            sqx_reg     <= NW'(in_reg.x * in_reg.x);
            sqy_reg     <= NW'(in_reg.y * in_reg.y);
            s2_item_reg <= s1_item_reg;
            n_reg       <= sqx_reg + sqy_reg;
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        item_t         p_item;
        logic [RW-1:0] p_rem;
        logic [W-1:0]  p_root;
        logic [NW-1:0] p_n;
        logic [RW-1:0] rem_cat;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [W-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign p_item = s2_item_reg;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_n    = n_reg;
        end
        else
        begin : g_rest
            assign p_item = sq_item_reg[k-1];
            assign p_rem  = sq_rem_reg[k-1];
            assign p_root = sq_root_reg[k-1];
            assign p_n    = sq_n_reg[k-1];
        end

        always_comb
        begin
            rem_cat = {p_rem[RW-3:0], p_n[NW-1:NW-2]};
            trial   = {p_root, 2'b01};
            if (rem_cat >= trial)
            begin
                rem_next  = rem_cat - trial;
                root_next = {p_root[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_cat;
                root_next = {p_root[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_item_reg[k] <= p_item;
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_n_reg[k]    <= p_n << 2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_item_reg <= sq_item_reg[W-1];
            rnd_pt_reg   <= PW'(sq_root_reg[W-1])
                          + PW'(sq_rem_reg[W-1] > RW'(sq_root_reg[W-1]));
        end
    end

    mcs_cordic #(
        .COMP_WIDTH    (COMP_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_phi (
        .clk   (clk),
        .en    (en),
        .x_in  ((W+2)'(rnd_item_reg.x)),
        .y_in  ((W+2)'(rnd_item_reg.y)),
        .angle (phi_ang)
    );

    mcs_cordic #(
        .COMP_WIDTH    (COMP_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_theta (
        .clk   (clk),
        .en    (en),
        .x_in  ((W+2)'(rnd_item_reg.z)),
        .y_in  ($signed({1'b0, rnd_pt_reg})),
        .angle (theta_ang)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_item_reg[0] <= rnd_item_reg;
            cd_pt_reg[0]   <= rnd_pt_reg;
            for (int j = 1; j < CL; j++)
            begin
                cd_item_reg[j] <= cd_item_reg[j-1];
                cd_pt_reg[j]   <= cd_pt_reg[j-1];
            end
        end
    end

    always_comb
    begin
        it_end = cd_item_reg[CL-1];
        pt_end = cd_pt_reg[CL-1];

        phi_a = phi_ang;
        if (phi_a < 0)
            phi_a = phi_a + TWO_PI_A;
        else if (phi_a >= TWO_PI_A)
            phi_a = phi_a - TWO_PI_A;
        phi_r = (AW'(phi_a) + HALF_A) >> SH;
        if (phi_r > PHI_MAX_A)
            phi_r = PHI_MAX_A;

        theta_a = theta_ang;
        if (theta_a < 0)
            theta_a = '0;
        else if (theta_a > PI_A)
            theta_a = PI_A;
        theta_r = (AW'(theta_a) + HALF_A) >> SH;
        if (theta_r > THETA_MAX_A)
            theta_r = THETA_MAX_A;

        xe = 64'(it_end.x);
        ye = 64'(it_end.y);
        ze = 64'(it_end.z);

        if (it_end.cart)
        begin
            pt_next    = MCS_PT_W'(pt_end);
            phi_next   = it_end.pok ? MCS_PHI_W'(phi_r) : '0;
            theta_next = it_end.tok ? MCS_THETA_W'(theta_r) : '0;
        end
        else
        begin
            if (xe < 0)
                pt_next = '0;
            else if (xe > MCS_PT_MAX)
                pt_next = MCS_PT_W'(MCS_PT_MAX);
            else
                pt_next = MCS_PT_W'(xe);

            if (ye < 0)
                phi_next = '0;
            else if (ye > PHI_MAX_L)
                phi_next = MCS_PHI_W'(PHI_MAX_L);
            else
                phi_next = MCS_PHI_W'(ye);

            if (ze < 0)
                theta_next = '0;
            else if (ze > THETA_MAX_L)
                theta_next = MCS_THETA_W'(THETA_MAX_L);
            else
                theta_next = MCS_THETA_W'(ze);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg    <= pt_next;
            phi_reg   <= phi_next;
            theta_reg <= theta_next;
            pok_reg   <= it_end.pok || !it_end.cart;
            tok_reg   <= it_end.tok || !it_end.cart;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MCS_OUT_DATA_W'({theta_reg, phi_reg, pt_reg});
    assign m_tuser  = {tok_reg, pok_reg};

endmodule
